// File: sv/bcbb_pkg.sv
// Package: shared types, register map and helpers for the background crop bounding box.
package bcbb_pkg;

  // Register map
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int CLOSE_W     = 8;
  localparam int SIDE_CFG_W  = 13;
  localparam int CHAN_W      = 8;

  localparam logic [1:0] REG_CLOSENESS    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [CLOSE_W-1:0]    CLOSENESS_RST    = 8'd15;
  localparam logic [SIDE_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [SIDE_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Result field widths
  localparam int POS_OUT_W  = 12;
  localparam int SIZE_OUT_W = 13;

  typedef struct packed {
    logic [CLOSE_W-1:0]    closeness;
    logic [SIDE_CFG_W-1:0] frame_width;
    logic [SIDE_CFG_W-1:0] frame_height;
  } cfg_t;

  // Absolute difference of two channel values
  function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

// File: sv/bcbb_regs.sv
// Configuration register file behind the APB-style port.
module bcbb_regs
  import bcbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write the addressed register; unmapped addresses drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closeness    <= CLOSENESS_RST;
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLOSENESS:    cfg.closeness    <= pwdata[CLOSE_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[SIDE_CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[SIDE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_CLOSENESS:    prdata = DATA_W'(cfg.closeness);
      REG_FRAME_WIDTH:  prdata = DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(cfg.frame_height);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: sv/background_crop_bounding_box.sv
// Top level: background-color autocrop bounding box over one RGB frame in raster order.
// Timing: a pixel is registered at acceptance; the crop result of a frame's last pixel
//   then passes from the input register to the output register and shows on m_tvalid,
//   later while a previous result still waits.
// Throughput: one pixel per cycle; input stalls only when a frame ends while the
//   previous crop result is still waiting at the output register.
// Reset (rst, synchronous): registers go to closeness 15, 640 x 480, frame position zero.
module background_crop_bounding_box
  import bcbb_pkg::*;
#(
  parameter int MAX_SIDE = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // Pixel input
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // red[7:0], green[15:8], blue[23:16]
  // Crop result output
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,   // crop_left[11:0], crop_top[23:12],
                                       // crop_width[36:24], crop_height[49:37], zero pad
  output logic              m_tuser,   // content_found
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = CW + 1;
  localparam int LW = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;

  cfg_t cfg;

  assign pready = 1'b1;

  bcbb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Effective frame size: zero reads as one, large values saturate
  logic [LW-1:0] fw_ext, fh_ext;
  logic [SW-1:0] fw_eff, fh_eff;

  assign fw_ext = LW'(cfg.frame_width);
  assign fh_ext = LW'(cfg.frame_height);

  always_comb begin
    if (fw_ext == '0)                fw_eff = SW'(1);
    else if (fw_ext > LW'(MAX_SIDE)) fw_eff = SW'(MAX_SIDE);
    else                             fw_eff = SW'(fw_ext);
    if (fh_ext == '0)                fh_eff = SW'(1);
    else if (fh_ext > LW'(MAX_SIDE)) fh_eff = SW'(MAX_SIDE);
    else                             fh_eff = SW'(fh_ext);
  end

  // Input register stage
  logic              pix_valid;
  logic [CHAN_W-1:0] pix_r, pix_g, pix_b;

  // Frame state
  logic [CW-1:0]     col_count, row_count;
  logic [CW-1:0]     min_col, max_col, min_row, max_row;
  logic              seen;
  logic [CHAN_W-1:0] bg_r, bg_g, bg_b;

  // Output register
  logic                  out_valid;
  logic [POS_OUT_W-1:0]  out_left, out_top;
  logic [SIZE_OUT_W-1:0] out_width, out_height;
  logic                  out_found;

  logic first_pix, is_content, last_col, last_row, frame_end, stall;
  logic advance;
  logic [CW-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
  logic [CW-1:0] left_next, top_next;
  logic [SW-1:0] width_next, height_next;
  logic [CHAN_W-1:0] ref_r, ref_g, ref_b;

  assign first_pix = (col_count == '0) && (row_count == '0);
  // The first pixel is its own background
  assign ref_r = first_pix ? pix_r : bg_r;
  assign ref_g = first_pix ? pix_g : bg_g;
  assign ref_b = first_pix ? pix_b : bg_b;

  assign is_content = !first_pix &&
                      ((chan_diff(pix_r, ref_r) > cfg.closeness) ||
                       (chan_diff(pix_g, ref_g) > cfg.closeness) ||
                       (chan_diff(pix_b, ref_b) > cfg.closeness));

  assign last_col  = (SW'(col_count) + SW'(1)) >= fw_eff;
  assign last_row  = (SW'(row_count) + SW'(1)) >= fh_eff;
  assign frame_end = last_col && last_row;

  // Hold the stage only when a frame ends and the previous result is still waiting
  assign stall    = pix_valid && frame_end && out_valid && !m_tready;
  assign advance  = pix_valid && !stall;
  assign s_tready = !pix_valid || !stall;

  // Extent update including the current pixel
  always_comb begin
    min_col_next = min_col;
    max_col_next = max_col;
    min_row_next = min_row;
    max_row_next = max_row;
    if (is_content) begin
      if (!seen) begin
        min_col_next = col_count;
        max_col_next = col_count;
        min_row_next = row_count;
        max_row_next = row_count;
      end else begin
        if (col_count < min_col) min_col_next = col_count;
        if (col_count > max_col) max_col_next = col_count;
        if (row_count < min_row) min_row_next = row_count;
        if (row_count > max_row) max_row_next = row_count;
      end
    end
  end

  // Crop rectangle with a one-pixel margin on left and top
  assign left_next   = (min_col_next != '0) ? (min_col_next - CW'(1)) : '0;
  assign top_next    = (min_row_next != '0) ? (min_row_next - CW'(1)) : '0;
  assign width_next  = SW'(max_col_next) + SW'(1) - SW'(left_next);
  assign height_next = SW'(max_row_next) + SW'(1) - SW'(top_next);

  // Register the incoming pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      pix_valid <= 1'b1;
    end else if (advance) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix_r <= s_tdata[7:0];
      pix_g <= s_tdata[15:8];
      pix_b <= s_tdata[23:16];
    end
  end

  // Advance frame position, background and extent
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      seen      <= 1'b0;
      bg_r      <= '0;
      bg_g      <= '0;
      bg_b      <= '0;
      min_col   <= '0;
      max_col   <= '0;
      min_row   <= '0;
      max_row   <= '0;
    end else if (advance) begin
      if (first_pix) begin
        bg_r <= pix_r;
        bg_g <= pix_g;
        bg_b <= pix_b;
      end
      min_col <= min_col_next;
      max_col <= max_col_next;
      min_row <= min_row_next;
      max_row <= max_row_next;
      if (!last_col) begin
        col_count <= col_count + CW'(1);
        seen      <= seen || is_content;
      end else begin
        col_count <= '0;
        if (!last_row) begin
          row_count <= row_count + CW'(1);
          seen      <= seen || is_content;
        end else begin
          row_count <= '0;
          seen      <= 1'b0;
        end
      end
    end
  end

  // Load the result register at frame end, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && frame_end) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      if (seen || is_content) begin
        out_left   <= POS_OUT_W'(left_next);
        out_top    <= POS_OUT_W'(top_next);
        out_width  <= SIZE_OUT_W'(width_next);
        out_height <= SIZE_OUT_W'(height_next);
        out_found  <= 1'b1;
      end else begin
        out_left   <= '0;
        out_top    <= '0;
        out_width  <= '0;
        out_height <= '0;
        out_found  <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_height, out_width, out_top, out_left};
  assign m_tuser  = out_found;

  // Extent stays ordered while content has been seen
  a_extent_order: assert property (@(posedge clk) disable iff (rst)
    seen |-> (min_col <= max_col) && (min_row <= max_row))
    else $error("content extent out of order");

  // A frame-end pixel that moves on always produces a result
  a_frame_result: assert property (@(posedge clk) disable iff (rst)
    (advance && frame_end) |=> out_valid)
    else $error("frame end without result");

  // A result with content has a nonempty rectangle
  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_found) |-> (out_width != '0) && (out_height != '0))
    else $error("content found but empty rectangle");

  // A result without content is all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |->
      (out_left == '0) && (out_top == '0) && (out_width == '0) && (out_height == '0))
    else $error("empty frame with nonzero rectangle");

  // Frame position stays within the largest supported side
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (SW'(col_count) < SW'(MAX_SIDE)) && (SW'(row_count) < SW'(MAX_SIDE)))
    else $error("frame position out of range");

endmodule
